>>> sv/b32b64_pkg.sv
`timescale 1ns / 1ps

package b32b64_pkg;

   localparam int IN_CHAR_W  = 8;
   localparam int OUT_CHAR_W = 7;
   localparam int MAX_RSP    = 4;
   localparam int RSP_IDX_W  = 2;
   localparam int RSP_CNT_W  = 3;
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = 3;
   localparam int QUEUE_CNT_W = 4;

   localparam logic [OUT_CHAR_W-1:0] PAD_CHAR = 7'd61;
   localparam logic [OUT_CHAR_W-1:0] END_CHAR = 7'd0;

   // One item's worth of result beats, handed from the core to the queue.
   typedef struct packed {
      logic                                  valid;
      logic [RSP_CNT_W-1:0]                  count;
      logic [MAX_RSP-1:0][OUT_CHAR_W-1:0]    chars;
      logic [MAX_RSP-1:0]                    lasts;
   } wr_type;

   // Base64 alphabet lookup.
   function automatic logic [OUT_CHAR_W-1:0] b64_char(input logic [5:0] idx);
      logic [OUT_CHAR_W-1:0] ch;
      if (idx < 6'd26) begin
         ch = 7'd65 + {1'b0, idx};
      end else if (idx < 6'd52) begin
         ch = 7'd97 + {1'b0, idx} - 7'd26;
      end else if (idx < 6'd62) begin
         ch = 7'd48 + {1'b0, idx} - 7'd52;
      end else if (idx == 6'd62) begin
         ch = 7'd43;
      end else begin
         ch = 7'd47;
      end
      return ch;
   endfunction

endpackage

>>> sv/base32_to_base64_transcoder.sv
`timescale 1ns / 1ps

// Base32 to base64 transcoder. Feed one base32 character per req beat
// (uppercase RFC 4648 alphabet; any other code, '=' included, is skipped)
// and mark the final character with req_last. Each completed byte is encoded
// at once into base64 and leaves as rsp beats, one character per beat; the
// last beat of a string carries rsp_last along with the '=' padding. A string
// that completes no byte, or whose last character adds nothing while no group
// is open, ends with a single beat of character 0 flagged last. Timing: a req
// beat lands in an input register and is encoded from there into a result
// queue of eight entries once the queue has room. The input side takes a beat
// every cycle as long as the queue has room for four more entries; the rsp
// port drains one beat per cycle while rsp_stall is low. An item causing k
// characters puts k beats into the queue (at most 4, on a final item with
// padding). Six base32 characters give five base64 characters on average, so
// with the rsp port open the input sustains one beat per cycle on dense text.
module base32_to_base64_transcoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_char,
   output logic       rsp_last
);

   b32b64_pkg::wr_type                      wr;
   logic                                    space_ok;
   logic                                    pop;
   logic [b32b64_pkg::QUEUE_CNT_W-1:0]      occupancy;

   // advance the queue head whenever the downstream takes a beat
   assign pop = rsp_valid && !rsp_stall;

   // decode, byte packing and base64 encoding
   b32b64_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_char  (req_char),
      .req_last  (req_last),
      .space_ok  (space_ok),
      .wr        (wr)
   );

   // result queue: takes up to four beats per item, hands out one per cycle unless rsp_stall is high
   b32b64_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_char  (rsp_char),
      .out_last  (rsp_last),
      .space_ok  (space_ok),
      .occupancy (occupancy)
   );

`ifndef SYNTH
   // queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      occupancy <= b32b64_pkg::QUEUE_CNT_W'(b32b64_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   // a write lands only when room for a full item was reserved
   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr.valid |-> space_ok)
      else $error("write into result queue without room");

   // a write carries between one and four beats, at most one of them flagged last
   a_write_count: assert property (@(posedge clock) disable iff (reset)
      wr.valid |-> (wr.count != 3'd0 && wr.count <= 3'd4 && $onehot0(wr.lasts)))
      else $error("malformed write to result queue");

   // occupancy does not change without a push or a pop
   a_occ_track: assert property (@(posedge clock) disable iff (reset)
      (!wr.valid && !pop) |=> $stable(occupancy))
      else $error("queue occupancy changed without push or pop");
`endif

endmodule

>>> sv/b32b64_core.sv
`timescale 1ns / 1ps

module b32b64_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [b32b64_pkg::IN_CHAR_W-1:0]     req_char,
   input  logic                                 req_last,
   input  logic                                 space_ok,
   output b32b64_pkg::wr_type                   wr
);

   localparam logic [1:0] PH_ZERO = 2'd0;
   localparam logic [1:0] PH_ONE  = 2'd1;
   localparam logic [1:0] PH_TWO  = 2'd2;

   logic                                 in_valid_ff, in_valid_in;
   logic [b32b64_pkg::IN_CHAR_W-1:0]     in_char_ff;
   logic                                 in_last_ff;

   logic [6:0] bits_ff, bits_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;
   logic [3:0] rest_ff, rest_in;
   logic [1:0] phase_ff, phase_in;

   logic load;
   logic fire;

   assign fire      = in_valid_ff && space_ok;
   assign req_stall = in_valid_ff && !space_ok;
   assign load      = req_valid && !req_stall;
   assign in_valid_in = load ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         bits_ff     <= '0;
         bit_cnt_ff  <= '0;
         rest_ff     <= '0;
         phase_ff    <= PH_ZERO;
      end else begin
         in_valid_ff <= in_valid_in;
         bits_ff     <= bits_in;
         bit_cnt_ff  <= bit_cnt_in;
         rest_ff     <= rest_in;
         phase_ff    <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_char_ff <= req_char;
         in_last_ff <= req_last;
      end
   end

   always_comb begin
      logic                                  sym_ok;
      logic [4:0]                            sym_val;
      logic [11:0]                           acc;
      logic [3:0]                            cnt;
      logic [2:0]                            rem;
      logic [7:0]                            byte_val;
      logic [7:0]                            mask;
      logic [b32b64_pkg::RSP_CNT_W-1:0]      n;
      logic [b32b64_pkg::MAX_RSP-1:0][b32b64_pkg::OUT_CHAR_W-1:0] chars;
      logic [b32b64_pkg::MAX_RSP-1:0]        lasts;

      sym_ok  = 1'b0;
      sym_val = '0;
      if (in_char_ff >= 8'd65 && in_char_ff <= 8'd90) begin
         sym_ok  = 1'b1;
         sym_val = 5'(in_char_ff - 8'd65);
      end else if (in_char_ff >= 8'd50 && in_char_ff <= 8'd55) begin
         sym_ok  = 1'b1;
         sym_val = 5'(in_char_ff - 8'd24);
      end

      acc      = {bits_ff, sym_val};
      cnt      = {1'b0, bit_cnt_ff} + 4'd5;
      rem      = 3'(cnt - 4'd8);
      byte_val = 8'(acc >> rem);
      mask     = (8'd1 << rem) - 8'd1;

      bits_in    = bits_ff;
      bit_cnt_in = bit_cnt_ff;
      rest_in    = rest_ff;
      phase_in   = phase_ff;
      n          = '0;
      chars      = '0;
      lasts      = '0;

      if (fire) begin
         if (sym_ok) begin
            if (cnt >= 4'd8) begin
               bit_cnt_in = rem;
               bits_in    = acc[6:0] & mask[6:0];
               case (phase_ff)
                  PH_ONE: begin
                     chars[n[1:0]] = b32b64_pkg::b64_char({rest_ff[1:0], byte_val[7:4]});
                     n = n + 3'd1;
                     rest_in  = byte_val[3:0];
                     phase_in = PH_TWO;
                  end
                  PH_TWO: begin
                     chars[n[1:0]] = b32b64_pkg::b64_char({rest_ff, byte_val[7:6]});
                     n = n + 3'd1;
                     chars[n[1:0]] = b32b64_pkg::b64_char(byte_val[5:0]);
                     n = n + 3'd1;
                     rest_in  = '0;
                     phase_in = PH_ZERO;
                  end
                  default: begin
                     // phase three cannot occur; it encodes as phase zero
                     chars[n[1:0]] = b32b64_pkg::b64_char(byte_val[7:2]);
                     n = n + 3'd1;
                     rest_in  = {2'b00, byte_val[1:0]};
                     phase_in = PH_ONE;
                  end
               endcase
            end else begin
               bits_in    = acc[6:0];
               bit_cnt_in = cnt[2:0];
            end
         end

         if (in_last_ff) begin
            if (phase_in == PH_ONE) begin
               chars[n[1:0]] = b32b64_pkg::b64_char({rest_in[1:0], 4'd0});
               n = n + 3'd1;
               chars[n[1:0]] = b32b64_pkg::PAD_CHAR;
               n = n + 3'd1;
               chars[n[1:0]] = b32b64_pkg::PAD_CHAR;
               n = n + 3'd1;
            end else if (phase_in == PH_TWO) begin
               chars[n[1:0]] = b32b64_pkg::b64_char({rest_in, 2'd0});
               n = n + 3'd1;
               chars[n[1:0]] = b32b64_pkg::PAD_CHAR;
               n = n + 3'd1;
            end
            if (n == 3'd0) begin
               chars[0] = b32b64_pkg::END_CHAR;
               n = 3'd1;
            end
            lasts[2'(n - 3'd1)] = 1'b1;
            // drop all leftover bits, back to the start of a string
            bits_in    = '0;
            bit_cnt_in = '0;
            rest_in    = '0;
            phase_in   = PH_ZERO;
         end
      end

      wr.valid = fire && (n != 3'd0);
      wr.count = n;
      wr.chars = chars;
      wr.lasts = lasts;
   end

endmodule

>>> sv/b32b64_queue.sv
`timescale 1ns / 1ps

module b32b64_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   input  b32b64_pkg::wr_type                    wr,
   input  logic                                  pop,
   output logic                                  out_valid,
   output logic [b32b64_pkg::OUT_CHAR_W-1:0]     out_char,
   output logic                                  out_last,
   output logic                                  space_ok,
   output logic [b32b64_pkg::QUEUE_CNT_W-1:0]    occupancy
);

   logic [b32b64_pkg::OUT_CHAR_W-1:0] char_mem_ff [b32b64_pkg::QUEUE_DEPTH];
   logic                              last_mem_ff [b32b64_pkg::QUEUE_DEPTH];

   logic [b32b64_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [b32b64_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [b32b64_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [b32b64_pkg::QUEUE_CNT_W-1:0] push_cnt;

   assign push_cnt  = wr.valid ? b32b64_pkg::QUEUE_CNT_W'(wr.count) : '0;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign wr_ptr_in = wr_ptr_ff + b32b64_pkg::QUEUE_PTR_W'(push_cnt);
   assign count_in  = count_ff + push_cnt - (pop ? 1'b1 : 1'b0);

   // room for a full item's worth of beats
   assign space_ok  = count_ff <= b32b64_pkg::QUEUE_CNT_W'(b32b64_pkg::QUEUE_DEPTH
                                                           - b32b64_pkg::MAX_RSP);
   assign out_valid = count_ff != '0;
   assign out_char  = char_mem_ff[rd_ptr_ff];
   assign out_last  = last_mem_ff[rd_ptr_ff];
   assign occupancy = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < b32b64_pkg::MAX_RSP; k++) begin
         if (wr.valid && (b32b64_pkg::RSP_CNT_W'(k) < wr.count)) begin
            char_mem_ff[wr_ptr_ff + b32b64_pkg::QUEUE_PTR_W'(k)] <= wr.chars[k];
            last_mem_ff[wr_ptr_ff + b32b64_pkg::QUEUE_PTR_W'(k)] <= wr.lasts[k];
         end
      end
   end

endmodule

>>> verif/base32_to_base64_transcoder_tb.sv
`timescale 1ns / 1ps

module base32_to_base64_transcoder_tb;

   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_ALPHA  = 112;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 16;

   // Standard base64 alphabet, element 0 holds 'A'.
   localparam logic [0:63][7:0] B64_TABLE =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // Bytes encoded so far in the open base64 group (mod 3).
   typedef enum logic [1:0] {
      GRP_FIRST  = 2'd0,
      GRP_SECOND = 2'd1,
      GRP_THIRD  = 2'd2,
      GRP_BAD    = 2'd3
   } group_phase_type;

   typedef enum int {
      STALL_OFF,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // One req beat waiting to go out; hold makes the driver wait until
   // every outstanding character has been seen on the rsp side.
   typedef struct {
      logic [7:0] ch;
      logic       last;
      logic       hold;
   } text_beat_type;

   typedef struct {
      logic [6:0] ch;
      logic       last;
   } b64_beat_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char  = 8'd0;
   logic       req_last  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_char;
   logic       rsp_last;

   base32_to_base64_transcoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_char  (req_char),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_char  (rsp_char),
      .rsp_last  (rsp_last)
   );

   always #(CLK_HALF) clock = ~clock;

   // Text beats still to send, and base64 beats predicted but not yet seen.
   text_beat_type text_queue[$];
   b64_beat_type  b64_expected[$];

   // Shadow of the transcoder state.
   logic [6:0]      frag_bits;
   logic [2:0]      frag_cnt;
   logic [3:0]      carry_bits;
   group_phase_type group_phase;
   logic            byte_seen;

   int sent_cnt     = 0;
   int taken_cnt    = 0;
   int error_cnt    = 0;
   int cycle_cnt    = 0;
   int strings_done = 0;
   int beats_seen   = 0;
   int end_markers  = 0;
   int pad_beats    = 0;
   int noise_items  = 0;
   int hold_points  = 0;

   // Driver state.
   text_beat_type  next_beat;
   int             burst_left = 1;
   int             gap_left   = 0;
   stall_mode_type stall_mode = STALL_OFF;
   int             stall_tick = 0;

   b64_beat_type   got_beat;

   task automatic report_mismatch(input string what);
      error_cnt++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic clear_shadow();
      frag_bits   = '0;
      frag_cnt    = '0;
      carry_bits  = '0;
      group_phase = GRP_FIRST;
      byte_seen   = 1'b0;
   endtask

   // Advance the shadow state by one accepted text beat and queue the
   // base64 characters it releases.
   task automatic predict_b64(input logic [7:0] c, input logic fin);
      logic [6:0]  out_q[$];
      logic [4:0]  sym;
      logic        is_sym;
      logic [11:0] acc;
      logic [7:0]  octet;
      int          cnt;
      int          rem;
      b64_beat_type b;
      is_sym = 1'b0;
      sym    = '0;
      if (c >= 8'd65 && c <= 8'd90) begin
         is_sym = 1'b1;
         sym    = 5'(c - 8'd65);
      end else if (c >= 8'd50 && c <= 8'd55) begin
         is_sym = 1'b1;
         sym    = 5'(c - 8'd50 + 8'd26);
      end
      if (is_sym) begin
         acc = {frag_bits, sym};
         cnt = int'(frag_cnt) + 5;
         if (cnt >= 8) begin
            rem       = cnt - 8;
            octet     = 8'(acc >> rem);
            frag_bits = 7'(acc & ((12'd1 << rem) - 12'd1));
            frag_cnt  = 3'(rem);
            byte_seen = 1'b1;
            case (group_phase)
               GRP_SECOND: begin
                  out_q.push_back(B64_TABLE[{carry_bits[1:0], octet[7:4]}][6:0]);
                  carry_bits  = octet[3:0];
                  group_phase = GRP_THIRD;
               end
               GRP_THIRD: begin
                  out_q.push_back(B64_TABLE[{carry_bits, octet[7:6]}][6:0]);
                  out_q.push_back(B64_TABLE[octet[5:0]][6:0]);
                  carry_bits  = '0;
                  group_phase = GRP_FIRST;
               end
               default: begin
                  out_q.push_back(B64_TABLE[octet[7:2]][6:0]);
                  carry_bits  = {2'b00, octet[1:0]};
                  group_phase = GRP_SECOND;
               end
            endcase
         end else begin
            frag_bits = acc[6:0];
            frag_cnt  = 3'(cnt);
         end
      end else begin
         noise_items++;
      end
      if (fin) begin
         // Drop leftover bits, zero-fill the open group and pad it.
         if (group_phase == GRP_SECOND) begin
            out_q.push_back(B64_TABLE[{carry_bits[1:0], 4'b0000}][6:0]);
            out_q.push_back(b32b64_pkg::PAD_CHAR);
            out_q.push_back(b32b64_pkg::PAD_CHAR);
            pad_beats += 2;
         end else if (group_phase == GRP_THIRD) begin
            out_q.push_back(B64_TABLE[{carry_bits, 2'b00}][6:0]);
            out_q.push_back(b32b64_pkg::PAD_CHAR);
            pad_beats += 1;
         end
         // Empty string or an end that adds nothing: one marker beat.
         if (out_q.size() == 0) begin
            out_q.push_back(b32b64_pkg::END_CHAR);
            end_markers++;
         end
         strings_done++;
         clear_shadow();
      end
      for (int k = 0; k < out_q.size(); k++) begin
         b.ch   = out_q[k];
         b.last = fin && (k == out_q.size() - 1);
         b64_expected.push_back(b);
      end
   endtask

   task automatic queue_text_beat(input logic [7:0] c, input logic fin, input logic hold);
      text_beat_type t;
      t.ch   = c;
      t.last = fin;
      t.hold = hold;
      text_queue.push_back(t);
   endtask

   // Queue a whole string, last flag on its final character.
   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         queue_text_beat(s[i], i == s.len() - 1, 1'b0);
      end
   endtask

   function automatic logic [7:0] pick_b32_char();
      int idx;
      idx = $urandom_range(0, 31);
      return (idx < 26) ? 8'(65 + idx) : 8'(50 + idx - 26);
   endfunction

   // Driver: present text beats at the falling edge; hold the payload
   // until the beat is taken, then advance through bursts and gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (sent_cnt == taken_cnt) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (text_queue.size() == 0) begin
            req_valid <= 1'b0;
         end else if (text_queue[0].hold && b64_expected.size() != 0) begin
            // Drain the rsp side fully before going on.
            req_valid <= 1'b0;
         end else begin
            next_beat = text_queue.pop_front();
            if (next_beat.hold) begin
               hold_points++;
            end
            req_valid <= 1'b1;
            req_char  <= next_beat.ch;
            req_last  <= next_beat.last;
            sent_cnt++;
            if (burst_left <= 1) begin
               // New burst; about a quarter of them follow with no gap.
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Receiver back-pressure: periodically pick one of four stall patterns at random,
   // including stretches with no stall at all.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_tick++;
         if (stall_tick % 48 == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
         end
         case (stall_mode)
            STALL_OFF:   rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((stall_tick % 5) < 2);
         endcase
      end
   end

   // Monitor: on each rising edge, predict from an accepted text beat first,
   // then check an accepted base64 beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_b64(req_char, req_last);
            taken_cnt++;
         end
         if (rsp_valid && !rsp_stall) begin
            beats_seen++;
            if (b64_expected.size() == 0) begin
               report_mismatch($sformatf("beat char=%0d last=%0b with nothing expected",
                                         rsp_char, rsp_last));
            end else begin
               got_beat = b64_expected.pop_front();
               if (rsp_char !== got_beat.ch) begin
                  report_mismatch($sformatf("beat %0d char got %0d want %0d",
                                            beats_seen, rsp_char, got_beat.ch));
               end
               if (rsp_last !== got_beat.last) begin
                  report_mismatch($sformatf("beat %0d last got %0b want %0b",
                                            beats_seen, rsp_last, got_beat.last));
               end
            end
         end
      end
   end

   // Cycle limit: end a hung run.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("cycle limit %0d hit with %0d beats still expected",
                  CYCLE_LIMIT, b64_expected.size());
         $display("base32_to_base64_transcoder verification failed");
         $finish;
      end
   end

   initial begin
      int  alpha_cnt;
      int  len;
      logic junk_only;
      logic hold_next;
      logic [7:0] c;

      clear_shadow();

      // Directed strings.
      queue_text("A");        // partial bits only: empty result
      queue_text("=");        // skipped char alone: empty result
      queue_text("AA");       // zero byte kept, two pads
      queue_text("777");      // all-ones byte
      queue_text("MFRGGA");   // full group, last char adds nothing: end marker
      queue_text("MZXQ");     // two bytes, one pad
      // Non-alphabet codes mixed in, then alphabet edges 'Z' and '2'.
      queue_text_beat(8'h00, 1'b0, 1'b0);
      queue_text_beat(8'hFF, 1'b0, 1'b0);
      queue_text_beat(8'h80, 1'b0, 1'b0);
      queue_text_beat("a",   1'b0, 1'b0);
      queue_text_beat("1",   1'b0, 1'b0);
      queue_text_beat("8",   1'b0, 1'b0);
      queue_text_beat("@",   1'b0, 1'b0);
      queue_text_beat("[",   1'b0, 1'b0);
      queue_text("Z2");

      // Random strings: mostly alphabet text with some noise, a few
      // noise-only strings; drain fully before the first and now and then.
      alpha_cnt = 0;
      hold_next = 1'b1;
      while (alpha_cnt < RANDOM_ALPHA) begin
         len       = $urandom_range(1, 20);
         junk_only = ($urandom_range(0, 9) == 0);
         for (int i = 0; i < len; i++) begin
            if (junk_only || $urandom_range(0, 9) == 0) begin
               c = 8'($urandom_range(0, 255));
            end else begin
               c = pick_b32_char();
               alpha_cnt++;
            end
            queue_text_beat(c, i == len - 1, hold_next);
            hold_next = 1'b0;
         end
         if ($urandom_range(0, 11) == 0) begin
            hold_next = 1'b1;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for all text to go in, then for every character to come out.
      while (text_queue.size() != 0 || sent_cnt != taken_cnt) @(posedge clock);
      while (b64_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d strings from %0d text beats (%0d skipped codes), %0d drain points",
               strings_done, taken_cnt, noise_items, hold_points);
      $display("checked %0d base64 beats: %0d pad beats, %0d end markers",
               beats_seen, pad_beats, end_markers);
      if (error_cnt == 0) begin
         $display("base32_to_base64_transcoder verification clean");
      end else begin
         $display("base32_to_base64_transcoder verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
sv/b32b64_pkg.sv
sv/b32b64_core.sv
sv/b32b64_queue.sv
sv/base32_to_base64_transcoder.sv
verif/base32_to_base64_transcoder_tb.sv
